/* sv/fsc_pkg.sv */
package fsc_pkg;

    localparam int DEF_MAX_PATTERN      = 16;
    localparam int DEF_SAMPLE_BITS      = 12;
    localparam int DEF_MAX_BLOCK_LENGTH = 4096;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int PAT_W     = 16;
    localparam int LEN_CFG_W = 5;
    localparam int THR_W     = 9;
    localparam int START_W   = 12;
    localparam int Q_BITS    = 8;

    localparam int OUT_TDATA_W = 16;

    localparam logic [PAT_W-1:0]     PAT_RST = 16'hAAAA;
    localparam logic [LEN_CFG_W-1:0] LEN_RST = 5'd16;
    localparam logic [THR_W-1:0]     THR_RST = 9'd179;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SYNC_PATTERN     = 2'd0,
        REG_PATTERN_LENGTH   = 2'd1,
        REG_DETECT_THRESHOLD = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROT,
        ST_SQ,
        ST_P1,
        ST_P2,
        ST_CMP,
        ST_REPORT,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_TC,
        ST_OUT
    } fsc_state_t;

endpackage

/* sv/fsc_cell.sv */
module fsc_cell #(
    parameter int SAMPLE_BITS = fsc_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          shift_en,
    input  logic signed [SAMPLE_BITS-1:0] re_in,
    input  logic [2*SAMPLE_BITS-1:0]      e_in,
    output logic signed [SAMPLE_BITS-1:0] re_out,
    output logic [2*SAMPLE_BITS-1:0]      e_out
);

    // One window position: the real part and the power of one sample.
    logic signed [SAMPLE_BITS-1:0] re_reg;
    logic [2*SAMPLE_BITS-1:0]      e_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            re_reg <= re_in;
            e_reg  <= e_in;
        end
    end

    assign re_out = re_reg;
    assign e_out  = e_reg;

endmodule

/* sv/fsc_mul.sv */
module fsc_mul #(
    parameter int A_W = 32,
    parameter int B_W = 28
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] p
);

    logic [A_W+B_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
        end
    end

    assign p = p_reg;

endmodule

/* sv/frame_sync_correlator.sv */
// A sample past the block limit is dropped at once; one that completes no window is only loaded
// into the cell ring. One that completes a window then makes one pass of the window around the
// ring and, when its correlation is positive, three products on the shared multiplier and a compare.
// After the last sample the threshold test (three more products when a peak was kept) and the result
// item follow, held while that item waits; no new sample is taken until the last one is through.
// Reset (aresetn low) clears the FSM, counts, best match and output valid and reloads the config.
module frame_sync_correlator #(
    parameter int MAX_PATTERN      = fsc_pkg::DEF_MAX_PATTERN,
    parameter int SAMPLE_BITS      = fsc_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_BLOCK_LENGTH = fsc_pkg::DEF_MAX_BLOCK_LENGTH
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // sample_re, sample_im
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    input  logic                                   s_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // sync_found, sync_start, block_too_short, block_overflow
    output logic [fsc_pkg::OUT_TDATA_W-1:0]        m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [fsc_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [fsc_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int T_W    = $clog2(MAX_PATTERN);
    localparam int CW     = SAMPLE_BITS + $clog2(MAX_PATTERN);
    localparam int CS_W   = CW + 1;
    localparam int ET_W   = 2 * SAMPLE_BITS;
    localparam int EW     = 2 * SAMPLE_BITS + $clog2(MAX_PATTERN);
    localparam int SQ_W   = 2 * CW;
    localparam int TH_W   = 2 * fsc_pkg::THR_W + LEN_W;
    localparam int MA     = (SQ_W > TH_W) ? SQ_W : TH_W;
    localparam int MB     = EW;
    localparam int PW     = MA + MB;
    localparam int LHS_W  = SQ_W + 2 * fsc_pkg::Q_BITS;
    localparam int CMP_W  = (PW > LHS_W) ? PW : LHS_W;
    localparam int CNT_W  = $clog2(MAX_BLOCK_LENGTH + 1);
    localparam int LC_W   = (LEN_W > fsc_pkg::LEN_CFG_W) ? LEN_W : fsc_pkg::LEN_CFG_W;
    localparam int INC_W  = LEN_W + 1;

    fsc_pkg::fsc_state_t state_reg, state_next;

    logic [fsc_pkg::PAT_W-1:0]     pat_cfg_reg, pat_cfg_next;
    logic [fsc_pkg::LEN_CFG_W-1:0] len_cfg_reg, len_cfg_next;
    logic [fsc_pkg::THR_W-1:0]     thr_reg, thr_next;

    logic signed [SAMPLE_BITS-1:0] in_re_reg, in_re_next;
    logic signed [SAMPLE_BITS-1:0] in_im_reg, in_im_next;
    logic                          in_last_reg, in_last_next;

    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic [T_W-1:0]            t_reg, t_next;
    logic [MAX_PATTERN-1:0]    pat_sh_reg, pat_sh_next;
    logic signed [CS_W-1:0]    acc_c_reg, acc_c_next;
    logic [EW-1:0]             acc_e_reg, acc_e_next;
    logic [SQ_W-1:0]           sq_reg, sq_next;
    logic [PW-1:0]             p1_reg, p1_next;
    logic [SQ_W-1:0]           best_sq_reg, best_sq_next;
    logic [EW-1:0]             best_e_reg, best_e_next;
    logic [fsc_pkg::START_W-1:0] best_start_reg, best_start_next;
    logic                      found_reg, found_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic                        out_found_reg, out_found_next;
    logic [fsc_pkg::START_W-1:0] out_start_reg, out_start_next;
    logic                        out_short_reg, out_short_next;
    logic                        out_ovf_reg, out_ovf_next;

    logic [LEN_W-1:0]         len;
    logic [CNT_W-1:0]         count_inc;
    logic                     short_blk;
    logic                     incl;
    logic [CW-1:0]            c_pos;
    logic signed [CS_W-1:0]   tail_re_ext;
    logic signed [ET_W-1:0]   re_sq;
    logic signed [ET_W-1:0]   im_sq;
    logic [ET_W-1:0]          new_e;
    logic [CNT_W-1:0]         start_diff;
    fsc_pkg::fsc_state_t      done_state;

    logic                     shift_en;
    logic                     shift_new;
    logic signed [SAMPLE_BITS-1:0] head_re;
    logic [ET_W-1:0]               head_e;
    logic signed [SAMPLE_BITS-1:0] cell_re [MAX_PATTERN];
    logic [ET_W-1:0]               cell_e  [MAX_PATTERN];

    logic              mul_en;
    logic [MA-1:0]     mul_a;
    logic [MB-1:0]     mul_b;
    logic [PW-1:0]     mul_p;

    // Window ring: cell 0 takes a new sample or the tail, the rest take their neighbor.
    assign head_re = shift_new ? in_re_reg : cell_re[MAX_PATTERN-1];
    assign head_e  = shift_new ? new_e : cell_e[MAX_PATTERN-1];

    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        if (i == 0) begin : g_head
            fsc_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .re_in    (head_re),
                .e_in     (head_e),
                .re_out   (cell_re[i]),
                .e_out    (cell_e[i])
            );
        end else begin : g_body
            fsc_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .re_in    (cell_re[i-1]),
                .e_in     (cell_e[i-1]),
                .re_out   (cell_re[i]),
                .e_out    (cell_e[i])
            );
        end
    end

    fsc_mul #(.A_W(MA), .B_W(MB)) u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    always_comb begin
        if (len_cfg_reg == '0) begin
            len = LEN_W'(1);
        end else if (LC_W'(len_cfg_reg) > LC_W'(MAX_PATTERN)) begin
            len = LEN_W'(MAX_PATTERN);
        end else begin
            len = LEN_W'(len_cfg_reg);
        end
    end

    assign re_sq       = in_re_reg * in_re_reg;
    assign im_sq       = in_im_reg * in_im_reg;
    assign new_e       = $unsigned(re_sq) + $unsigned(im_sq);
    assign count_inc   = count_reg + CNT_W'(1);
    assign short_blk   = count_reg < CNT_W'(len);
    assign incl        = (INC_W'(t_reg) + INC_W'(len)) >= INC_W'(MAX_PATTERN);
    assign c_pos       = acc_c_reg[CW-1:0];
    assign tail_re_ext = CS_W'(cell_re[MAX_PATTERN-1]);
    assign start_diff  = count_reg - CNT_W'(len);
    assign done_state  = in_last_reg ? fsc_pkg::ST_REPORT : fsc_pkg::ST_IDLE;

    always_comb begin
        state_next      = state_reg;
        pat_cfg_next    = pat_cfg_reg;
        len_cfg_next    = len_cfg_reg;
        thr_next        = thr_reg;
        in_re_next      = in_re_reg;
        in_im_next      = in_im_reg;
        in_last_next    = in_last_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        t_next          = t_reg;
        pat_sh_next     = pat_sh_reg;
        acc_c_next      = acc_c_reg;
        acc_e_next      = acc_e_reg;
        sq_next         = sq_reg;
        p1_next         = p1_reg;
        best_sq_next    = best_sq_reg;
        best_e_next     = best_e_reg;
        best_start_next = best_start_reg;
        found_next      = found_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_found_next  = out_found_reg;
        out_start_next  = out_start_reg;
        out_short_next  = out_short_reg;
        out_ovf_next    = out_ovf_reg;
        s_tready        = 1'b0;
        shift_en        = 1'b0;
        shift_new       = 1'b0;
        mul_en          = 1'b0;
        mul_a           = '0;
        mul_b           = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            fsc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    in_last_next = s_tlast;
                    if (count_reg >= CNT_W'(MAX_BLOCK_LENGTH)) begin
                        // Samples past the maximum block length are dropped.
                        ovf_next   = 1'b1;
                        state_next = s_tlast ? fsc_pkg::ST_REPORT : fsc_pkg::ST_IDLE;
                    end else begin
                        in_re_next = s_tdata[SAMPLE_BITS-1:0];
                        in_im_next = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
                        state_next = fsc_pkg::ST_LOAD;
                    end
                end
            end
            fsc_pkg::ST_LOAD: begin
                shift_en   = 1'b1;
                shift_new  = 1'b1;
                count_next = count_inc;
                if (count_inc >= CNT_W'(len)) begin
                    t_next      = '0;
                    pat_sh_next = MAX_PATTERN'(pat_cfg_reg);
                    acc_c_next  = '0;
                    acc_e_next  = '0;
                    state_next  = fsc_pkg::ST_ROT;
                end else begin
                    state_next = done_state;
                end
            end
            fsc_pkg::ST_ROT: begin
                // The tail cell shows the oldest sample first; only the last len count.
                shift_en = 1'b1;
                if (incl) begin
                    if (pat_sh_reg[0]) begin
                        acc_c_next = acc_c_reg + tail_re_ext;
                    end else begin
                        acc_c_next = acc_c_reg - tail_re_ext;
                    end
                    acc_e_next  = acc_e_reg + EW'(cell_e[MAX_PATTERN-1]);
                    pat_sh_next = pat_sh_reg >> 1;
                end
                t_next = t_reg + T_W'(1);
                if (t_reg == T_W'(MAX_PATTERN - 1)) begin
                    // The newest sample is added in this cycle, so the full sum is tested.
                    state_next = (!acc_c_next[CS_W-1] && (acc_c_next != '0)) ?
                                 fsc_pkg::ST_SQ : done_state;
                end
            end
            fsc_pkg::ST_SQ: begin
                mul_en     = 1'b1;
                mul_a      = MA'(c_pos);
                mul_b      = MB'(c_pos);
                state_next = fsc_pkg::ST_P1;
            end
            fsc_pkg::ST_P1: begin
                mul_en     = 1'b1;
                mul_a      = mul_p[MA-1:0];
                mul_b      = best_e_reg;
                sq_next    = mul_p[SQ_W-1:0];
                state_next = fsc_pkg::ST_P2;
            end
            fsc_pkg::ST_P2: begin
                mul_en     = 1'b1;
                mul_a      = MA'(best_sq_reg);
                mul_b      = acc_e_reg;
                p1_next    = mul_p;
                state_next = fsc_pkg::ST_CMP;
            end
            fsc_pkg::ST_CMP: begin
                // corr^2 * best_energy > best_corr^2 * energy, the roots cancel.
                if (p1_reg > mul_p) begin
                    best_sq_next    = sq_reg;
                    best_e_next     = acc_e_reg;
                    best_start_next = fsc_pkg::START_W'(start_diff);
                end
                state_next = done_state;
            end
            fsc_pkg::ST_REPORT: begin
                if (short_blk || best_sq_reg == '0) begin
                    found_next = !short_blk && (thr_reg == '0);
                    state_next = fsc_pkg::ST_OUT;
                end else begin
                    state_next = fsc_pkg::ST_T1;
                end
            end
            fsc_pkg::ST_T1: begin
                mul_en     = 1'b1;
                mul_a      = MA'(thr_reg);
                mul_b      = MB'(thr_reg);
                state_next = fsc_pkg::ST_T2;
            end
            fsc_pkg::ST_T2: begin
                mul_en     = 1'b1;
                mul_a      = mul_p[MA-1:0];
                mul_b      = MB'(len);
                state_next = fsc_pkg::ST_T3;
            end
            fsc_pkg::ST_T3: begin
                mul_en     = 1'b1;
                mul_a      = mul_p[MA-1:0];
                mul_b      = best_e_reg;
                state_next = fsc_pkg::ST_TC;
            end
            fsc_pkg::ST_TC: begin
                found_next = (CMP_W'(best_sq_reg) << (2 * fsc_pkg::Q_BITS)) >= CMP_W'(mul_p);
                state_next = fsc_pkg::ST_OUT;
            end
            fsc_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next  = 1'b1;
                    out_found_next = found_reg;
                    out_start_next = (short_blk || best_sq_reg == '0) ? '0 : best_start_reg;
                    out_short_next = short_blk;
                    out_ovf_next   = ovf_reg;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    best_sq_next    = '0;
                    best_e_next     = EW'(1);
                    best_start_next = '0;
                    state_next      = fsc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fsc_pkg::ST_IDLE;
            end
        endcase

        if (cfg_valid) begin
            case (fsc_pkg::cfg_reg_t'(cfg_index))
                fsc_pkg::REG_SYNC_PATTERN: begin
                    pat_cfg_next = cfg_data[fsc_pkg::PAT_W-1:0];
                end
                fsc_pkg::REG_PATTERN_LENGTH: begin
                    len_cfg_next = cfg_data[fsc_pkg::LEN_CFG_W-1:0];
                end
                fsc_pkg::REG_DETECT_THRESHOLD: begin
                    thr_next = cfg_data[fsc_pkg::THR_W-1:0];
                end
                default: begin
                    pat_cfg_next = pat_cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= fsc_pkg::ST_IDLE;
            pat_cfg_reg    <= fsc_pkg::PAT_RST;
            len_cfg_reg    <= fsc_pkg::LEN_RST;
            thr_reg        <= fsc_pkg::THR_RST;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            best_sq_reg    <= '0;
            best_e_reg     <= EW'(1);
            best_start_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pat_cfg_reg    <= pat_cfg_next;
            len_cfg_reg    <= len_cfg_next;
            thr_reg        <= thr_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            best_sq_reg    <= best_sq_next;
            best_e_reg     <= best_e_next;
            best_start_reg <= best_start_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_re_reg     <= in_re_next;
        in_im_reg     <= in_im_next;
        in_last_reg   <= in_last_next;
        t_reg         <= t_next;
        pat_sh_reg    <= pat_sh_next;
        acc_c_reg     <= acc_c_next;
        acc_e_reg     <= acc_e_next;
        sq_reg        <= sq_next;
        p1_reg        <= p1_next;
        found_reg     <= found_next;
        out_found_reg <= out_found_next;
        out_start_reg <= out_start_next;
        out_short_reg <= out_short_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {1'b0, out_ovf_reg, out_short_reg, out_start_reg, out_found_reg};

endmodule

/* bench/frame_sync_correlator_test.sv */
module frame_sync_correlator_test;

    localparam int MAX_PAT    = fsc_pkg::DEF_MAX_PATTERN;
    localparam int MAX_BLOCK  = fsc_pkg::DEF_MAX_BLOCK_LENGTH;
    localparam int S_TDATA_W  = ((2*fsc_pkg::DEF_SAMPLE_BITS+7)/8)*8;
    localparam int SETTLE     = 40;
    localparam int END_WAIT   = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int SEND_IDLE [4] = '{0, 53, 0, 16};
    localparam int RECV_STALL [4] = '{0, 0, 53, 16};

    typedef struct packed {
        logic        overflow;
        logic        too_short;
        logic [11:0] start;
        logic        found;
    } sync_report_t;

    typedef enum logic {
        PLAN_SAMPLE,
        PLAN_CONFIG
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t         kind;
        logic signed [11:0] re;
        logic signed [11:0] im;
        logic               last;
        logic               checked;
        sync_report_t       want;
        logic [15:0]        pattern;
        logic [4:0]         length;
        logic [8:0]         threshold;
    } plan_row_t;

    localparam sync_report_t REP_MISS  = '0;
    localparam sync_report_t REP_SHORT = '{1'b0, 1'b1, 12'd0, 1'b0};
    localparam sync_report_t REP_HIT   = '{1'b0, 1'b0, 12'd0, 1'b1};

    // Rows marked as checked carry their expected result; the others use the predictor.
    localparam plan_row_t PLAN [26] = '{
        '{PLAN_SAMPLE,  2047, -2048, 1'b1, 1'b1, REP_SHORT, 16'h0000, 5'd0,  9'd0},
        '{PLAN_CONFIG,     0,     0, 1'b0, 1'b0, REP_MISS,  16'hAAAA, 5'd2,  9'd179},
        '{PLAN_SAMPLE,     0,     0, 1'b0, 1'b0, REP_MISS,  16'h0000, 5'd0,  9'd0},
        '{PLAN_SAMPLE,     0,     0, 1'b0, 1'b0, REP_MISS,  16'h0000, 5'd0,  9'd0},
        '{PLAN_SAMPLE,     0,     0, 1'b1, 1'b1, REP_MISS,  16'h0000, 5'd0,  9'd0},
        '{PLAN_SAMPLE, -2048,     0, 1'b0, 1'b0, REP_MISS,  16'h0000, 5'd0,  9'd0},
        '{PLAN_SAMPLE,  2047,     0, 1'b1, 1'b1, REP_HIT,   16'h0000, 5'd0,  9'd0},
        '{PLAN_CONFIG,     0,     0, 1'b0, 1'b0, REP_MISS,  16'hAAAA, 5'd2,  9'd0},
        '{PLAN_SAMPLE,  2047,     0, 1'b0, 1'b0, REP_MISS,  16'h0000, 5'd0,  9'd0},
        '{PLAN_SAMPLE, -2048,     0, 1'b1, 1'b1, REP_HIT,   16'h0000, 5'd0,  9'd0},
        '{PLAN_CONFIG,     0,     0, 1'b0, 1'b0, REP_MISS,  16'hAAAA, 5'd2,  9'd511},
        '{PLAN_SAMPLE, -2048,     0, 1'b0, 1'b0, REP_MISS,  16'h0000, 5'd0,  9'd0},
        '{PLAN_SAMPLE,  2047,     0, 1'b1, 1'b1, REP_MISS,  16'h0000, 5'd0,  9'd0},
        '{PLAN_CONFIG,     0,     0, 1'b0, 1'b0, REP_MISS,  16'hAAAA, 5'd2,  9'd256},
        '{PLAN_SAMPLE, -2047,     0, 1'b0, 1'b0, REP_MISS,  16'h0000, 5'd0,  9'd0},
        '{PLAN_SAMPLE,  2047,     0, 1'b1, 1'b1, REP_HIT,   16'h0000, 5'd0,  9'd0},
        '{PLAN_CONFIG,     0,     0, 1'b0, 1'b0, REP_MISS,  16'h0001, 5'd0,  9'd256},
        '{PLAN_SAMPLE,    -3,     0, 1'b0, 1'b0, REP_MISS,  16'h0000, 5'd0,  9'd0},
        '{PLAN_SAMPLE,     4,     0, 1'b0, 1'b0, REP_MISS,  16'h0000, 5'd0,  9'd0},
        '{PLAN_SAMPLE,     9,     9, 1'b0, 1'b0, REP_MISS,  16'h0000, 5'd0,  9'd0},
        '{PLAN_SAMPLE,     9,     0, 1'b1, 1'b0, REP_MISS,  16'h0000, 5'd0,  9'd0},
        '{PLAN_CONFIG,     0,     0, 1'b0, 1'b0, REP_MISS,  16'h0003, 5'd2,  9'd179},
        '{PLAN_SAMPLE,   100,    -7, 1'b0, 1'b0, REP_MISS,  16'h0000, 5'd0,  9'd0},
        '{PLAN_SAMPLE,   100,     5, 1'b0, 1'b0, REP_MISS,  16'h0000, 5'd0,  9'd0},
        '{PLAN_CONFIG,     0,     0, 1'b0, 1'b0, REP_MISS,  16'h0000, 5'd2,  9'd179},
        '{PLAN_SAMPLE,   -50,  2047, 1'b1, 1'b0, REP_MISS,  16'h0000, 5'd0,  9'd0}
    };

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [S_TDATA_W-1:0]            s_tdata = '0;
    logic                            s_tlast = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [fsc_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [fsc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [fsc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    sync_report_t pending_reports [$];
    int           mismatch_count = 0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    logic         hold_req = 1'b0;
    bit           hold_taken = 1'b0;
    int           hold_left = 0;

    logic [fsc_pkg::PAT_W-1:0]     cur_pattern = fsc_pkg::PAT_RST;
    logic [fsc_pkg::LEN_CFG_W-1:0] cur_length = fsc_pkg::LEN_RST;
    logic [fsc_pkg::THR_W-1:0]     cur_threshold = fsc_pkg::THR_RST;
    logic signed [11:0]   hist_re [MAX_PAT];
    logic signed [11:0]   hist_im [MAX_PAT];
    int                   samples_seen;
    longint               peak_corr;
    longint               peak_energy;
    int                   peak_start;
    bit                   block_overflowed;

    frame_sync_correlator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(string what);
        if (mismatch_count < 50) begin
            $display("mismatch: %s", what);
        end
        mismatch_count++;
    endtask

    function automatic int window_len();
        if (cur_length == 0) return 1;
        if (cur_length > MAX_PAT) return MAX_PAT;
        return int'(cur_length);
    endfunction

    function automatic void clear_block();
        for (int k = 0; k < MAX_PAT; k++) begin
            hist_re[k] = '0;
            hist_im[k] = '0;
        end
        samples_seen = 0;
        peak_corr = 0;
        peak_energy = 1;
        peak_start = 0;
        block_overflowed = 1'b0;
    endfunction

    function automatic bit track_sample(logic signed [11:0] re, logic signed [11:0] im,
                                        logic last, output sync_report_t rep);
        int     len;
        int     j;
        longint corr;
        longint energy;
        longint vr;
        longint vi;
        len = window_len();
        rep = '0;
        if (samples_seen >= MAX_BLOCK) begin
            block_overflowed = 1'b1;
        end else begin
            for (int k = MAX_PAT - 1; k > 0; k--) begin
                hist_re[k] = hist_re[k-1];
                hist_im[k] = hist_im[k-1];
            end
            hist_re[0] = re;
            hist_im[0] = im;
            samples_seen++;
            if (samples_seen >= len) begin
                corr = 0;
                energy = 0;
                for (int k = 0; k < len; k++) begin
                    j = len - 1 - k;
                    vr = hist_re[j];
                    vi = hist_im[j];
                    corr = cur_pattern[k] ? corr + vr : corr - vr;
                    energy += vr * vr + vi * vi;
                end
                if (corr > 0 && corr * corr * peak_energy > peak_corr * peak_corr * energy) begin
                    peak_corr = corr;
                    peak_energy = energy;
                    peak_start = samples_seen - len;
                end
            end
        end
        if (!last) return 1'b0;
        if (samples_seen < len) begin
            rep.too_short = 1'b1;
        end else if (peak_corr == 0) begin
            rep.found = (cur_threshold == 0);
        end else begin
            rep.found = peak_corr * peak_corr * 65536
                        >= longint'(cur_threshold) * cur_threshold * peak_energy * len;
            rep.start = peak_start[11:0];
        end
        rep.overflow = block_overflowed;
        clear_block();
        return 1'b1;
    endfunction

    task automatic check_report(logic [fsc_pkg::OUT_TDATA_W-1:0] word);
        sync_report_t got;
        sync_report_t want;
        got = word[14:0];
        if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("result item 0x%04h arrived with nothing expected", word));
        end else begin
            want = pending_reports.pop_front();
            if (got.found !== want.found)
                report_mismatch($sformatf("sync_found got %0d, expected %0d",
                                          got.found, want.found));
            if (got.start !== want.start)
                report_mismatch($sformatf("sync_start got %0d, expected %0d",
                                          got.start, want.start));
            if (got.too_short !== want.too_short)
                report_mismatch($sformatf("block_too_short got %0d, expected %0d",
                                          got.too_short, want.too_short));
            if (got.overflow !== want.overflow)
                report_mismatch($sformatf("block_overflow got %0d, expected %0d",
                                          got.overflow, want.overflow));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_report(m_tdata);
            if (hold_req && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic signed [11:0] clip12(int v);
        if (v > 2047) return 12'sd2047;
        if (v < -2048) return 12'h800;
        return v[11:0];
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic send_sample(logic signed [11:0] re, logic signed [11:0] im, logic last,
                               bit fixed, sync_report_t fixed_rep);
        sync_report_t rep;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {im, re};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (track_sample(re, im, last, rep)) begin
            pending_reports = {pending_reports, (fixed ? fixed_rep : rep)};
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_all(logic [15:0] pattern, logic [15:0] len_word, logic [15:0] thr_word);
        cfg_valid <= 1'b1;
        cfg_index <= fsc_pkg::REG_SYNC_PATTERN;
        cfg_data <= pattern;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= fsc_pkg::REG_PATTERN_LENGTH;
        cfg_data <= len_word;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= fsc_pkg::REG_DETECT_THRESHOLD;
        cfg_data <= thr_word;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_pattern = pattern;
        cur_length = len_word[fsc_pkg::LEN_CFG_W-1:0];
        cur_threshold = thr_word[fsc_pkg::THR_W-1:0];
    endtask

    task automatic pick_config();
        logic [15:0] pat;
        logic [15:0] len_word;
        logic [15:0] thr_word;
        case ($urandom_range(3))
            0: pat = 16'h0000;
            1: pat = 16'hFFFF;
            default: pat = 16'($urandom);
        endcase
        len_word = 16'($urandom);
        case ($urandom_range(9))
            0: len_word[4:0] = 5'd0;
            1: len_word[4:0] = 5'd1;
            2: len_word[4:0] = 5'd16;
            3: len_word[4:0] = 5'd17;
            4: len_word[4:0] = 5'd31;
            default: len_word[4:0] = 5'($urandom_range(2, 6));
        endcase
        thr_word = 16'($urandom);
        case ($urandom_range(7))
            0: thr_word[8:0] = 9'd0;
            1: thr_word[8:0] = 9'd256;
            2: thr_word[8:0] = 9'd257;
            3: thr_word[8:0] = 9'd511;
            default: thr_word[8:0] = 9'($urandom_range(120, 250));
        endcase
        drain();
        write_all(pat, len_word, thr_word);
    endtask

    task automatic send_block(int n, int plant_at, int amp, int span, bit wild);
        logic signed [11:0] re;
        logic signed [11:0] im;
        int                 len;
        len = window_len();
        for (int i = 0; i < n; i++) begin
            if (plant_at >= 0 && i >= plant_at && i < plant_at + len) begin
                re = clip12((cur_pattern[i - plant_at] ? amp : -amp) + jitter(span));
                im = clip12(jitter(span));
            end else if (wild) begin
                re = 12'($urandom);
                im = 12'($urandom);
            end else begin
                re = clip12(jitter(span));
                im = clip12(jitter(span));
            end
            send_sample(re, im, i == n - 1, 1'b0, '0);
        end
    endtask

    task automatic send_random_block(inout int items);
        int len;
        int n;
        int plant_at;
        int span;
        len = window_len();
        if ($urandom_range(4) == 0)
            n = (len > 1) ? $urandom_range(1, len - 1) : 1;
        else
            n = $urandom_range(len, len + 10);
        plant_at = (n >= len && $urandom_range(9) < 7) ? $urandom_range(0, n - len) : -1;
        span = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 200);
        send_block(n, plant_at, $urandom_range(1, 2047), span, $urandom_range(9) < 3);
        items += n;
    endtask

    initial begin
        int items;
        int blocks;
        int w;
        clear_block();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (PLAN[r]) begin
            if (PLAN[r].kind == PLAN_CONFIG) begin
                drain();
                write_all(PLAN[r].pattern, {11'd0, PLAN[r].length}, {7'd0, PLAN[r].threshold});
            end else begin
                send_sample(PLAN[r].re, PLAN[r].im, PLAN[r].last, PLAN[r].checked, PLAN[r].want);
            end
        end

        // The receiver holds off while one-sample blocks keep coming, so the input backs up.
        drain();
        write_all(16'hAAAA, 16'd2, 16'd179);
        hold_req <= 1'b1;
        repeat (24) send_sample(12'($urandom), 12'($urandom), 1'b1, 1'b0, '0);

        drain();
        write_all(16'h0009, 16'd4, 16'd200);
        send_block(MAX_BLOCK + 3, MAX_BLOCK - 4, 1500, 40, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            send_idle_pct = SEND_IDLE[ph];
            stall_pct = RECV_STALL[ph];
            items = 0;
            blocks = 0;
            while (items < 100 || blocks < 12) begin
                if (blocks % 3 == 0) pick_config();
                send_random_block(items);
                blocks++;
            end
        end

        s_tvalid <= 1'b0;
        for (w = 0; w < END_WAIT && pending_reports.size() != 0; w++) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (pending_reports.size() != 0)
            report_mismatch($sformatf("%0d expected result items never arrived",
                                      pending_reports.size()));
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
